// ===== src/interval_map_range_table_core_macros.svh =====
// Assertion macros shared by the range table design.
`ifndef INTERVAL_MAP_RANGE_TABLE_CORE_MACROS_SVH
`define INTERVAL_MAP_RANGE_TABLE_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define IMR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define IMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/imrt_pkg.sv =====
package imrt_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefKeyWidth   = 32;
  localparam int DefValueWidth = 8;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Source of a cell's new entry on commit.
  localparam logic [2:0] SEL_KEEP  = 3'd0;
  localparam logic [2:0] SEL_START = 3'd1;
  localparam logic [2:0] SEL_END   = 3'd2;
  localparam logic [2:0] SEL_SHIFT = 3'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_OUT
  } state_t;

  // Command broadcast to every cell in the update cycle.
  typedef struct packed {
    logic commit;
  } cell_cmd_t;

endpackage

// ===== src/imrt_cell.sv =====
// One breakpoint cell. On commit each cell loads either its own entry, the
// range start, the range end or the shifted entry chosen for its position.
module imrt_cell import imrt_pkg::*; #(
  parameter int KeyWidth   = DefKeyWidth,
  parameter int ValueWidth = DefValueWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [KeyWidth-1:0]   s_key,
  input  logic [KeyWidth-1:0]   e_key,
  input  logic [ValueWidth-1:0] s_val,
  input  logic [ValueWidth-1:0] e_val,
  // Position class of this cell in the new table.
  input  logic [2:0]            sel,
  input  logic [KeyWidth-1:0]   src_key,
  input  logic [ValueWidth-1:0] src_val,
  input  logic                  src_valid,
  output logic [KeyWidth-1:0]   key,
  output logic [ValueWidth-1:0] val,
  output logic                  valid
);

  logic [KeyWidth-1:0]   key_next;
  logic [ValueWidth-1:0] val_next;
  logic                  valid_next;

  // Select the new contents of this cell.
  always_comb begin
    key_next   = key;
    val_next   = val;
    valid_next = valid;
    case (sel)
      SEL_START: begin
        key_next = s_key; val_next = s_val; valid_next = 1'b1;
      end
      SEL_END: begin
        key_next = e_key; val_next = e_val; valid_next = 1'b1;
      end
      SEL_SHIFT: begin
        key_next = src_key; val_next = src_val; valid_next = src_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.commit) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      key <= key_next;
      val <= val_next;
    end
  end

endmodule

// ===== src/interval_map_range_table_core.sv =====
// Range table core: a chain of breakpoint cells with compare flags per cell.
// Operands are registered on input transfer (capture), then evaluated, then the result is valid.
// The next item is taken only once the result transfers.
// The evaluate cycle compares every cell against the keys and encodes the prefix edges.
// Reset clears the entry valid bits, the entry count, the controller and default_value.
module interval_map_range_table_core import imrt_pkg::*; #(
  parameter int TableDepth = DefTableDepth,
  parameter int KeyWidth   = DefKeyWidth,
  parameter int ValueWidth = DefValueWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [KeyWidth-1:0]   range_start,
  input  logic [KeyWidth-1:0]   range_end,
  input  logic [ValueWidth-1:0] new_value,
  input  logic [KeyWidth-1:0]   query_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ValueWidth-1:0] read_value,
  output logic [1:0]            status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ValueWidth-1:0] cfg_data
);

`include "interval_map_range_table_core_macros.svh"

  localparam int CntW = $clog2(TableDepth + 3);

  state_t state, state_next;
  logic [ValueWidth-1:0] default_value;
  logic                  op;
  logic [KeyWidth-1:0]   s_key, e_key, q_key;
  logic [ValueWidth-1:0] s_val;
  logic [CntW-1:0]       below, span, count;
  logic [ValueWidth-1:0] e_val, q_val;

  logic [KeyWidth-1:0]   ckey [TableDepth];
  logic [ValueWidth-1:0] cval [TableDepth];
  logic                  cvalid [TableDepth];
  logic [2:0]            csel [TableDepth];
  logic [KeyWidth-1:0]   skey [TableDepth];
  logic [ValueWidth-1:0] sval [TableDepth];
  logic                  svld [TableDepth];
  logic                  lt_s [TableDepth];
  logic                  le_e [TableDepth];
  logic                  le_q [TableDepth];
  logic                  last_s [TableDepth];
  logic                  last_e [TableDepth];
  logic                  last_q [TableDepth];
  logic [CntW-1:0]       nb, ne;
  logic [ValueWidth-1:0] ve_or, vq_or;
  cell_cmd_t             cmd;
  logic                  empty_rng, full_tbl;
  logic [CntW:0]         total;

  // Keys compare in signed order.
  function automatic logic sle(logic [KeyWidth-1:0] a, logic [KeyWidth-1:0] b);
    return $signed(a) <= $signed(b);
  endfunction

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_value <= cfg_data;
    end
  end

  // Controller.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op    <= opcode;
      s_key <= range_start;
      e_key <= range_end;
      s_val <= new_value;
      q_key <= query_key;
    end
  end

  // Per-cell compare flags; the table is sorted so the flags form prefixes.
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      lt_s[i] = cvalid[i] && !sle(s_key, ckey[i]);
      le_e[i] = cvalid[i] && sle(ckey[i], e_key);
      le_q[i] = cvalid[i] && sle(ckey[i], q_key);
    end
  end

  // The last set flag of each prefix marks its length and the value it selects.
  always_comb begin
    for (int i = 0; i < TableDepth - 1; i++) begin
      last_s[i] = lt_s[i] && !lt_s[i+1];
      last_e[i] = le_e[i] && !le_e[i+1];
      last_q[i] = le_q[i] && !le_q[i+1];
    end
    last_s[TableDepth-1] = lt_s[TableDepth-1];
    last_e[TableDepth-1] = le_e[TableDepth-1];
    last_q[TableDepth-1] = le_q[TableDepth-1];
  end

  always_comb begin
    nb = '0;
    ne = '0;
    ve_or = '0;
    vq_or = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (last_s[i]) nb = nb | CntW'(i + 1);
      if (last_e[i]) begin
        ne    = ne | CntW'(i + 1);
        ve_or = ve_or | cval[i];
      end
      if (last_q[i]) vq_or = vq_or | cval[i];
    end
  end

  // Counts and the looked-up values in the evaluate cycle.
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      below <= nb;
      span  <= ne - nb;
      e_val <= le_e[0] ? ve_or : default_value;
      q_val <= le_q[0] ? vq_or : default_value;
    end
  end

  assign total     = {1'b0, count} - {1'b0, span} + (CntW+1)'(2);
  assign empty_rng = sle(e_key, s_key);
  assign full_tbl  = total > (CntW+1)'(TableDepth);

  assign cmd.commit = (state == S_OUT) && out_ready && (op == OP_ASSIGN) &&
                      !empty_rng && !full_tbl;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= total[CntW-1:0];
    end
  end

  // Shift source for each cell: the entry that lands here after the update.
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      logic [CntW:0] ii;
      logic [CntW:0] src;
      ii = (CntW+1)'(i);
      csel[i] = SEL_KEEP;
      skey[i] = ckey[i];
      sval[i] = cval[i];
      svld[i] = cvalid[i];
      src = ii + {1'b0, span} - (CntW+1)'(2);
      if (ii < {1'b0, below}) begin
        csel[i] = SEL_KEEP;
      end else if (ii == {1'b0, below}) begin
        csel[i] = SEL_START;
      end else if (ii == {1'b0, below} + (CntW+1)'(1)) begin
        csel[i] = SEL_END;
      end else begin
        csel[i] = SEL_SHIFT;
        svld[i] = 1'b0;
        for (int j = 0; j < TableDepth; j++) begin
          if (src == (CntW+1)'(j)) begin
            skey[i] = ckey[j];
            sval[i] = cval[j];
            svld[i] = cvalid[j];
          end
        end
      end
    end
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    imrt_cell #(.KeyWidth(KeyWidth), .ValueWidth(ValueWidth)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .s_key(s_key), .e_key(e_key), .s_val(s_val), .e_val(e_val),
      .sel(csel[g]), .src_key(skey[g]), .src_val(sval[g]), .src_valid(svld[g]),
      .key(ckey[g]), .val(cval[g]), .valid(cvalid[g])
    );
  end

  // Result fields.
  always_comb begin
    out_valid  = (state == S_OUT);
    read_value = (op == OP_LOOKUP) ? q_val : '0;
    if (op == OP_LOOKUP) status = ST_DONE;
    else if (empty_rng) status = ST_EMPTY;
    else if (full_tbl) status = ST_FULL;
    else status = ST_DONE;
  end

  `IMR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CntW'(TableDepth), "count too big")
  `IMR_ASSERT_IMP(a_lookup_nocommit, clk, rst, op == OP_LOOKUP, !cmd.commit, "lookup wrote")
  `IMR_ASSERT_NEXT(a_out_after_eval, clk, rst, state == S_EVAL, out_valid, "no result")

endmodule
